// ----- rtl/core/utr_pkg.sv -----
// ----------------------------------------------------------------------------
// utr_pkg
// shared widths, defaults and divider interface types of the resampler
// ----------------------------------------------------------------------------
package utr_pkg;

  localparam int NUM_CH          = 9;
  localparam int DATA_W          = 32;
  localparam int TIME_W          = 32;
  localparam int CFG_W           = 20;
  localparam int DEF_MAX_SAMPLES = 64;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DIV_W           = 32;
  localparam int DIV_CNT_W       = 6;
  localparam int TDATA_W         = (NUM_CH + 1) * DATA_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10000);

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem_init;
    logic [DIV_W-1:0]     bits;
    logic [DIV_CNT_W-1:0] count;
    logic [DIV_W-1:0]     den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- rtl/core/uniform_trajectory_resampler.sv -----
// ----------------------------------------------------------------------------
// uniform_trajectory_resampler
// resamples trajectory knots onto a uniform time grid, nine blend lanes
// ----------------------------------------------------------------------------
// the first knot of a run goes through ST_BL1 and ST_BL2 to ST_SEND for its sample
// each grid sample waits for the alpha divider, then the blend states ST_BL1, ST_BL2
// a knot goes through ST_LIM, ST_CHK and ST_LOOP to its samples, a last knot then
// to its end sample; cut grid points wait in ST_REMW, output stalls hold ST_SEND
// at most one knot in flight; the next request is taken once it is done
// reset: synchronous, clears run state, sample_interval returns to 10000
// ----------------------------------------------------------------------------
module uniform_trajectory_resampler #(
  parameter int MAX_SAMPLES_PER_KNOT = utr_pkg::DEF_MAX_SAMPLES,
  parameter int FRACTION_BITS        = utr_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [utr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // knot_time, pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,
  // ctrl_drive, ctrl_strafe, ctrl_turn
  input  logic [utr_pkg::TDATA_W-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sample_time, out_pos_x, out_pos_y, out_heading, out_vel_x, out_vel_y,
  // out_yaw_rate, out_drive, out_strafe, out_turn
  output logic [utr_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast,
  // gap_truncated
  output logic [0:0]                    m_axis_tuser
);
  import utr_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES_PER_KNOT + 1);
  localparam int LW = CW + CFG_W;
  localparam int GW = TIME_W + 1;
  localparam int XW = TIME_W + FRACTION_BITS + 1;
  localparam logic [GW-1:0]            T_LIMIT = GW'(1) << TIME_W;
  localparam logic [FRACTION_BITS:0]   ONE     = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
  localparam logic [CW-1:0]            LIM_RUN = CW'(MAX_SAMPLES_PER_KNOT);
  localparam logic [CW-1:0]            LIM_END = CW'(MAX_SAMPLES_PER_KNOT - 1);
  localparam int                       CTRL_LO = 6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LIM, ST_CHK, ST_LOOP, ST_DIVW, ST_BL1, ST_BL2, ST_SEND,
    ST_TAIL, ST_REMW
  } state_t;

  function automatic logic [GW-1:0] cap_time(input logic [GW:0] v);
    cap_time = (v > {1'b0, T_LIMIT}) ? T_LIMIT : v[GW-1:0];
  endfunction

  state_t              state;
  logic [CFG_W-1:0]    sample_interval;
  logic [CFG_W-1:0]    dt;
  logic                have_prev;
  logic [TIME_W-1:0]   prev_t;
  logic [DATA_W-1:0]   prev_val [NUM_CH];
  logic [DATA_W-1:0]   cur_val  [NUM_CH];
  logic [TIME_W-1:0]   t;
  logic                lst;
  logic [GW-1:0]       g;
  logic [CW-1:0]       limit;
  logic [CW-1:0]       cnt;
  logic [LW-1:0]       lim_dt;
  logic                trunc;
  logic                a_first;
  logic [FRACTION_BITS:0] alpha;
  logic [TIME_W-1:0]   smp_time;
  logic                smp_last;
  logic                smp_zero;
  logic                ret_loop;
  logic [DATA_W-1:0]   lane_y [NUM_CH];
  logic                cond;
  logic [GW+1:0]       lim_sum;
  logic [TIME_W-1:0]   den_a;
  logic [TIME_W-1:0]   num_a;
  logic [XW-1:0]       x_a;
  logic [TIME_W-1:0]   span;
  div_req_t            dreq;
  div_rsp_t            drsp;
  logic [TDATA_W-1:0]  out_word;

  assign dt        = (sample_interval == '0) ? CFG_W'(1) : sample_interval;
  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    cond    = lst ? (g < {1'b0, t}) : (g <= {1'b0, t});
    lim_sum = (GW+2)'(g) + (GW+2)'(lim_dt);
    den_a   = t - prev_t;
    num_a   = g[TIME_W-1:0] - prev_t;
    x_a     = (XW'(num_a) << FRACTION_BITS) + XW'(den_a >> 1);
    span    = t - g[TIME_W-1:0];
    dreq    = '0;
    if (state == ST_LOOP) begin
      dreq.start    = (cnt < limit) && cond;
      dreq.rem_init = x_a[XW-1 -: TIME_W];
      dreq.bits     = DIV_W'(x_a[FRACTION_BITS:0]) << (DIV_W - FRACTION_BITS - 1);
      dreq.count    = DIV_CNT_W'(FRACTION_BITS + 1);
      dreq.den      = den_a;
    end else if (state == ST_TAIL) begin
      dreq.start    = !lst && trunc;
      dreq.rem_init = '0;
      dreq.bits     = span;
      dreq.count    = DIV_CNT_W'(DIV_W);
      dreq.den      = DIV_W'(dt);
    end
  end

  utr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    utr_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
      .clk   (clk),
      .a     (a_first ? cur_val[i] : prev_val[i]),
      .b     (cur_val[i]),
      .alpha (alpha),
      .y     (lane_y[i])
    );
  end

  // merge lanes into the output word
  always_comb begin
    out_word[TIME_W-1:0] = smp_time;
    for (int i = 0; i < NUM_CH; i++) begin
      out_word[TIME_W + i*DATA_W +: DATA_W] =
        (smp_zero && i >= CTRL_LO) ? '0 : lane_y[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      sample_interval <= CFG_RESET;
      have_prev       <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_interval <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_SEND) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            t   <= s_axis_tdata[TIME_W-1:0];
            lst <= s_axis_tlast;
            for (int i = 0; i < NUM_CH; i++) begin
              cur_val[i] <= s_axis_tdata[TIME_W + i*DATA_W +: DATA_W];
            end
            if (!have_prev) begin
              a_first  <= 1'b1;
              alpha    <= '0;
              smp_time <= s_axis_tdata[TIME_W-1:0];
              smp_last <= s_axis_tlast;
              smp_zero <= 1'b0;
              trunc    <= 1'b0;
              ret_loop <= 1'b0;
              if (!s_axis_tlast) begin
                have_prev <= 1'b1;
                prev_t    <= s_axis_tdata[TIME_W-1:0];
                for (int i = 0; i < NUM_CH; i++) begin
                  prev_val[i] <= s_axis_tdata[TIME_W + i*DATA_W +: DATA_W];
                end
                g <= cap_time((GW+1)'(s_axis_tdata[TIME_W-1:0]) + (GW+1)'(dt));
              end
              state <= ST_BL1;
            end else begin
              a_first <= 1'b0;
              limit   <= s_axis_tlast ? LIM_END : LIM_RUN;
              state   <= ST_LIM;
            end
          end
        end
        ST_LIM: begin
          lim_dt <= LW'(limit) * LW'(dt);
          state  <= ST_CHK;
        end
        ST_CHK: begin
          trunc <= lst ? (lim_sum < (GW+2)'(t)) : (lim_sum <= (GW+2)'(t));
          cnt   <= '0;
          state <= ST_LOOP;
        end
        ST_LOOP: begin
          state <= dreq.start ? ST_DIVW : ST_TAIL;
        end
        ST_DIVW: begin
          if (drsp.done) begin
            alpha    <= drsp.quo[FRACTION_BITS:0];
            smp_time <= g[TIME_W-1:0];
            smp_last <= 1'b0;
            smp_zero <= 1'b0;
            ret_loop <= 1'b1;
            state    <= ST_BL1;
          end
        end
        ST_BL1: state <= ST_BL2;
        ST_BL2: state <= ST_SEND;
        ST_SEND: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid   <= 1'b1;
            m_axis_tdata    <= out_word;
            m_axis_tlast    <= smp_last;
            m_axis_tuser[0] <= trunc;
            if (ret_loop) begin
              g     <= cap_time((GW+1)'(g) + (GW+1)'(dt));
              cnt   <= cnt + 1'b1;
              state <= ST_LOOP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_TAIL: begin
          if (lst) begin
            alpha     <= (t > prev_t) ? ONE : '0;
            smp_time  <= t;
            smp_last  <= 1'b1;
            smp_zero  <= 1'b1;
            ret_loop  <= 1'b0;
            have_prev <= 1'b0;
            state     <= ST_BL1;
          end else if (trunc) begin
            state <= ST_REMW;
          end else begin
            prev_t   <= t;
            prev_val <= cur_val;
            state    <= ST_IDLE;
          end
        end
        ST_REMW: begin
          if (drsp.done) begin
            g        <= cap_time((GW+1)'(t) - (GW+1)'(drsp.rem) + (GW+1)'(dt));
            prev_t   <= t;
            prev_val <= cur_val;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/utr_div.sv -----
// ----------------------------------------------------------------------------
// utr_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module utr_div (
  input  logic              clk,
  input  logic              rst,
  input  utr_pkg::div_req_t req,
  output utr_pkg::div_rsp_t rsp
);
  import utr_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     bits;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     den;
  logic                 done;
  logic [DIV_W:0]       r2;
  logic                 qb;

  always_comb begin
    r2 = {rem, bits[DIV_W-1]};
    qb = (r2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
        rem  <= req.rem_init;
        bits <= req.bits;
        den  <= req.den;
        quo  <= '0;
      end else if (busy) begin
        rem  <= qb ? DIV_W'(r2 - {1'b0, den}) : r2[DIV_W-1:0];
        bits <= {bits[DIV_W-2:0], 1'b0};
        quo  <= {quo[DIV_W-2:0], qb};
        cnt  <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

// ----- rtl/core/utr_lane.sv -----
// ----------------------------------------------------------------------------
// utr_lane
// one channel blend a + (b - a) * alpha, rounded to nearest, two stages
// ----------------------------------------------------------------------------
module utr_lane #(
  parameter int FRACTION_BITS = utr_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic signed [utr_pkg::DATA_W-1:0]   a,
  input  logic signed [utr_pkg::DATA_W-1:0]   b,
  input  logic        [FRACTION_BITS:0]       alpha,
  output logic signed [utr_pkg::DATA_W-1:0]   y
);
  import utr_pkg::*;

  localparam int PW = DATA_W + FRACTION_BITS + 3;
  localparam int SW = PW + 1;

  logic signed [DATA_W:0]          d;
  logic signed [FRACTION_BITS+1:0] al;
  logic signed [PW-1:0]            prod;
  logic signed [DATA_W-1:0]        a_d;
  logic signed [SW-1:0]            s;

  always_comb begin
    d  = {b[DATA_W-1], b} - {a[DATA_W-1], a};
    al = {1'b0, alpha};
    s  = (SW'(a_d) <<< FRACTION_BITS) + SW'(prod)
       + (SW'(1) <<< (FRACTION_BITS - 1));
  end

  always_ff @(posedge clk) begin
    prod <= d * al;
    a_d  <= a;
    y    <= s[FRACTION_BITS +: DATA_W];
  end

endmodule

// ----- rtl/core/utr_checker.sv -----
// ----------------------------------------------------------------------------
// utr_checker
// port level checks of the resampler, bound to the top level
// ----------------------------------------------------------------------------
module utr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [utr_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a knot is in work");

  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("sample shown in the cycle after the request");

endmodule

bind uniform_trajectory_resampler utr_checker u_utr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and self-checking for uniform_trajectory_resampler: directed
// trajectories cover extreme values, single-knot runs, zero-length, backward
// and time-capped segments and sample cuts; random trajectories under three
// idling patterns and one long output stall; every sample is checked field
// by field against an in-bench prediction of the grid and the blend
// ----------------------------------------------------------------------------
module tb_top;
  import utr_pkg::*;

  localparam int  CUT_LIMIT   = 64;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  DRAIN_WAIT  = 60;
  localparam longint unsigned TIME_END = 64'h1_0000_0000;

  typedef struct packed {
    logic                          last;
    logic [NUM_CH-1:0][DATA_W-1:0] ch;
    logic [TIME_W-1:0]             t;
  } knot_t;

  typedef struct packed {
    logic                          trunc;
    logic                          last;
    logic [NUM_CH-1:0][DATA_W-1:0] ch;
    logic [TIME_W-1:0]             t;
  } sample_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;
  logic [0:0]           m_axis_tuser;

  // resampler state as predicted
  logic [CFG_W-1:0]              grid_step;
  logic [TIME_W-1:0]             prev_t;
  logic [NUM_CH-1:0][DATA_W-1:0] prev_ch;
  longint unsigned               next_grid;
  bit                            mid_run;

  sample_t expected_samples[$];
  int  snd_idle = 0, rcv_idle = 0;
  bit  rcv_hold = 1'b0;
  int  knots_sent = 0, samples_seen = 0, cut_samples = 0;
  int  mismatches = 0, cycles = 0;

  uniform_trajectory_resampler dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("uniform_trajectory_resampler verification failed");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] blend(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                              longint unsigned alpha);
    longint s;
    s = longint'(signed'(a)) * ((64'sd1 <<< DEF_FRAC_BITS) - longint'(alpha))
      + longint'(signed'(b)) * longint'(alpha);
    return DATA_W'((s + (64'sd1 <<< (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS);
  endfunction

  function automatic sample_t make_sample(longint unsigned t,
                                          logic [NUM_CH-1:0][DATA_W-1:0] a,
                                          logic [NUM_CH-1:0][DATA_W-1:0] b,
                                          longint unsigned alpha, bit zero_ctrl, bit last);
    sample_t r;
    r.t = TIME_W'(t);
    for (int i = 0; i < NUM_CH; i++)
      r.ch[i] = (zero_ctrl && i >= 6) ? '0 : blend(a[i], b[i], alpha);
    r.last = last;
    r.trunc = 1'b0;
    return r;
  endfunction

  function automatic longint unsigned clip_grid(longint unsigned t);
    return (t > TIME_END) ? TIME_END : t;
  endfunction

  function automatic void enqueue_sample(sample_t s);
    expected_samples.insert(expected_samples.size(), s);
  endfunction

  // grid samples caused by one knot
  function automatic void resample_knot(knot_t k);
    sample_t         batch[$];
    longint unsigned dt, den, num, alpha, kt;
    int              lim;
    bit              cut;
    dt = (grid_step == 0) ? 1 : grid_step;
    kt = k.t;
    cut = 1'b0;
    if (!mid_run) begin
      enqueue_sample(make_sample(kt, k.ch, k.ch, 0, 1'b0, k.last));
      if (!k.last) begin
        mid_run = 1'b1;
        prev_t = k.t;
        prev_ch = k.ch;
        next_grid = clip_grid(kt + dt);
      end
      return;
    end
    lim = k.last ? CUT_LIMIT - 1 : CUT_LIMIT;
    while (batch.size() < lim && (k.last ? next_grid < kt : next_grid <= kt)) begin
      den = kt - prev_t;
      num = next_grid - prev_t;
      alpha = ((num << DEF_FRAC_BITS) + (den >> 1)) / den;
      batch.insert(batch.size(), make_sample(next_grid, prev_ch, k.ch, alpha, 1'b0, 1'b0));
      next_grid = clip_grid(next_grid + dt);
    end
    if (k.last ? next_grid < kt : next_grid <= kt) begin
      cut = 1'b1;
      if (!k.last)
        next_grid = clip_grid(next_grid + ((kt - next_grid) / dt + 1) * dt);
    end
    if (k.last) begin
      alpha = (kt > prev_t) ? (64'd1 << DEF_FRAC_BITS) : 0;
      batch.insert(batch.size(), make_sample(kt, prev_ch, k.ch, alpha, 1'b1, 1'b1));
      mid_run = 1'b0;
    end else begin
      prev_t = k.t;
      prev_ch = k.ch;
    end
    foreach (batch[i]) begin
      batch[i].trunc = cut;
      enqueue_sample(batch[i]);
    end
  endfunction

  always @(negedge clk)
    m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);

  always @(posedge clk) begin
    sample_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.t = m_axis_tdata[TIME_W-1:0];
      got.ch = m_axis_tdata[TDATA_W-1:TIME_W];
      got.last = m_axis_tlast;
      got.trunc = m_axis_tuser[0];
      samples_seen++;
      if (got.trunc) cut_samples++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample: time %h last %b", got.t, got.last);
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("sample mismatch: time exp %h got %h, last exp %b got %b",
                     want.t, got.t, want.last, got.last);
            $display("  cut exp %b got %b", want.trunc, got.trunc);
            for (int i = 0; i < NUM_CH; i++)
              if (want.ch[i] !== got.ch[i])
                $display("  channel %0d exp %h got %h", i, want.ch[i], got.ch[i]);
          end
        end
      end
    end
  end

  task automatic send_knot(knot_t k);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {k.ch, k.t};
    s_axis_tlast = k.last;
    do @(posedge clk); while (!s_axis_tready);
    resample_knot(k);
    knots_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_interval(logic [CFG_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    grid_step = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic knot_t rand_knot(logic [TIME_W-1:0] t, bit last);
    knot_t k;
    int    r;
    k.t = t;
    k.last = last;
    for (int i = 0; i < NUM_CH; i++) begin
      r = $urandom_range(99);
      k.ch[i] = (r < 8) ? 32'h8000_0000 : (r < 16) ? 32'h7fff_ffff : $urandom;
    end
    return k;
  endfunction

  task automatic test_directed();
    // lone knot of a run
    send_knot(rand_knot(32'd5, 1'b1));
    // extremes, zero-length and backward segments
    send_knot('{1'b0, {NUM_CH{32'h8000_0000}}, 32'd0});
    send_knot('{1'b0, {NUM_CH{32'h7fff_ffff}}, 32'd25000});
    send_knot(rand_knot(32'd25000, 1'b0));
    send_knot(rand_knot(32'd20000, 1'b0));
    send_knot(rand_knot(32'd40000, 1'b1));
    // too many grid points, middle and last knot
    send_knot(rand_knot(32'd100, 1'b0));
    send_knot(rand_knot(32'd700100, 1'b0));
    send_knot(rand_knot(32'd2000100, 1'b1));
    // grid running past the top of the time range
    send_knot(rand_knot(32'hffff_0000, 1'b0));
    send_knot(rand_knot(32'hffff_fff0, 1'b0));
    send_knot(rand_knot(32'hffff_ffff, 1'b1));
    // zero interval acts as one
    write_interval('0);
    send_knot(rand_knot(32'd0, 1'b0));
    send_knot(rand_knot(32'd3, 1'b0));
    send_knot(rand_knot(32'd3, 1'b1));
    // widest interval
    write_interval('1);
    send_knot(rand_knot(32'd0, 1'b0));
    send_knot(rand_knot(32'd3000000, 1'b0));
    send_knot(rand_knot(32'd3000001, 1'b1));
    write_interval(CFG_W'(1000000));
    send_knot(rand_knot(32'h1234_5678, 1'b0));
    send_knot(rand_knot(32'h1243_97b8, 1'b1));
    write_interval(CFG_W'(1));
    send_knot(rand_knot(32'd10, 1'b0));
    send_knot(rand_knot(32'd12, 1'b1));
  endtask

  task automatic test_random_runs(int n_knots);
    longint unsigned t, dt, step;
    int              len, r, stop_at;
    knot_t           k;
    stop_at = knots_sent + n_knots;
    dt = (grid_step == 0) ? 1 : grid_step;
    while (knots_sent < stop_at) begin
      len = $urandom_range(1, 8);
      t = ($urandom_range(9) == 0) ? 0 : $urandom;
      for (int j = 0; j < len; j++) begin
        if (j > 0) begin
          r = $urandom_range(99);
          if (r < 3) step = dt * $urandom_range(65, 90);
          else if (r < 8) step = 0;
          else step = $urandom_range(0, 32'(3 * dt));
          if (r >= 8 && r < 11) t = (t > step) ? t - step : 0;
          else t = t + step;
        end
        if (t >= TIME_END) t = TIME_END - 1;
        k = rand_knot(TIME_W'(t), (j == len - 1) || (t == TIME_END - 1));
        send_knot(k);
        if (k.last) break;
      end
    end
  endtask

  task automatic test_output_stall();
    fork
      begin
        rcv_hold = 1'b1;
        repeat (800) @(posedge clk);
        rcv_hold = 1'b0;
      end
      test_random_runs(20);
    join
  endtask

  initial begin
    grid_step = CFG_RESET;
    mid_run = 1'b0;
    prev_t = '0;
    prev_ch = '0;
    next_grid = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    snd_idle = 21; rcv_idle = 83;
    write_interval(CFG_W'($urandom_range(1, 50)));
    test_random_runs(140);
    snd_idle = 83; rcv_idle = 21;
    write_interval(CFG_W'($urandom_range(1000, 20000)));
    test_random_runs(140);
    snd_idle = 0; rcv_idle = 0;
    write_interval(CFG_W'($urandom_range(100000, 1048575)));
    test_random_runs(140);
    test_output_stall();
    wait_drained();

    $display("covered %0d knots and %0d samples (%0d from cut knots) over interval settings",
             knots_sent, samples_seen, cut_samples);
    $display("including zero, one and widest interval, a long output stall and %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_samples.size() == 0)
      $display("uniform_trajectory_resampler verification clean");
    else
      $display("uniform_trajectory_resampler verification failed");
    $finish;
  end
endmodule
